@@ hdl/position_hold_pi_tiered_integral_assert.svh @@
// Assertion macros shared by the RTL files.
`ifndef POSITION_HOLD_PI_TIERED_INTEGRAL_ASSERT_SVH
`define POSITION_HOLD_PI_TIERED_INTEGRAL_ASSERT_SVH

`ifndef SYNTHESIS
`define PHTI_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define PHTI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define PHTI_ASSERT_NOW(label, clk, rst, ante, cons)
`define PHTI_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ hdl/phti_pkg.sv @@
package phti_pkg;

   localparam int unsigned QDEPTH = 2;
   localparam int unsigned QPTR_W = 1;
   localparam int unsigned QCNT_W = 2;
   localparam logic [QCNT_W-1:0] QFULL = QCNT_W'(QDEPTH);

   localparam int unsigned PADDR_W = 5;

   localparam logic [2:0] REG_PROP_GAIN     = 3'd0;
   localparam logic [2:0] REG_INTEG_GAIN    = 3'd1;
   localparam logic [2:0] REG_INTEG_FLOOR   = 3'd2;
   localparam logic [2:0] REG_INTEG_CEILING = 3'd3;
   localparam logic [2:0] REG_DRIVE_FLOOR   = 3'd4;
   localparam logic [2:0] REG_DRIVE_CEILING = 3'd5;

   localparam logic signed [31:0] INTEG_FLOOR_RST   = -32'sd98304000;
   localparam logic signed [31:0] INTEG_CEILING_RST = 32'sd98304000;
   localparam logic signed [15:0] DRIVE_FLOOR_RST   = -16'sd3000;
   localparam logic signed [15:0] DRIVE_CEILING_RST = 16'sd3000;

   localparam logic signed [12:0] P_MAX = 13'sd3000;
   localparam logic signed [12:0] P_MIN = -13'sd3000;
   localparam logic signed [15:0] DRIVE_PIN_MAX = 16'sd3000;
   localparam logic signed [15:0] DRIVE_PIN_MIN = -16'sd3000;
   localparam logic signed [31:0] PIN_ACCUM_MAX = 32'sd98304000;
   localparam logic signed [31:0] PIN_ACCUM_MIN = -32'sd98304000;

   localparam logic signed [15:0] SPEED_MAX = 16'sd50;
   localparam logic signed [15:0] SPEED_MIN = -16'sd50;

   localparam logic [15:0] TIER_COARSE = 16'd250;
   localparam logic [15:0] TIER_MID    = 16'd100;
   localparam logic [15:0] TIER_FINE   = 16'd30;

   typedef struct packed {
      logic signed [16:0] err;
      logic signed [11:0] se;
      logic [8:0]         sa;
      logic               spd_over;
   } q_entry_type;

   typedef struct packed {
      logic [14:0]        prop_gain;
      logic [7:0]         integ_gain;
      logic signed [31:0] integ_floor;
      logic signed [31:0] integ_ceiling;
      logic signed [15:0] drive_floor;
      logic signed [15:0] drive_ceiling;
   } cfg_type;

endpackage

@@ hdl/position_hold_pi_tiered_integral.sv @@
// Position-hold PI step with tiered integral gain and anti-windup. Each request carries
// target, measured position and speed and yields one response with drive, error and the
// updated integrator. The front end computes the error and its tier and parks the request
// in a two-entry queue, so up to two queued requests, one request in the back end and one
// waiting response can be held. The back end runs one request at a time through its steps
// (load and P product, Ki product, tier product, integrator clamp, drive clamp), all
// three products on one shared 21x17 multiplier; it takes the next request only after the
// drive clamp step has handed its response to the output register. Registers sit on an APB
// port, words at 4*index; write them only while the block is idle.
module position_hold_pi_tiered_integral (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [15:0]            req_position_target,
   input  logic signed [15:0]            req_position_measured,
   input  logic signed [15:0]            req_speed_measured,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [15:0]            rsp_drive_value,
   output logic signed [16:0]            rsp_position_error,
   output logic signed [31:0]            rsp_integ_value,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [phti_pkg::PADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);

   phti_pkg::cfg_type     cfg;
   phti_pkg::q_entry_type q_head;
   logic                  q_valid;
   logic                  q_pop;

   phti_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   phti_front u_front (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_position_target   (req_position_target),
      .req_position_measured (req_position_measured),
      .req_speed_measured    (req_speed_measured),
      .q_pop                 (q_pop),
      .q_valid               (q_valid),
      .q_head                (q_head)
   );

   phti_back u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .q_valid            (q_valid),
      .q_head             (q_head),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_drive_value    (rsp_drive_value),
      .rsp_position_error (rsp_position_error),
      .rsp_integ_value    (rsp_integ_value)
   );

endmodule

@@ hdl/phti_csr.sv @@
module phti_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [phti_pkg::PADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready,
   output phti_pkg::cfg_type             cfg
);

   phti_pkg::cfg_type cfg_ff;
   logic [2:0]        index;
   logic              wr_en;

   assign index      = csr_paddr[4:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain     <= '0;
         cfg_ff.integ_gain    <= '0;
         cfg_ff.integ_floor   <= phti_pkg::INTEG_FLOOR_RST;
         cfg_ff.integ_ceiling <= phti_pkg::INTEG_CEILING_RST;
         cfg_ff.drive_floor   <= phti_pkg::DRIVE_FLOOR_RST;
         cfg_ff.drive_ceiling <= phti_pkg::DRIVE_CEILING_RST;
      end else if (wr_en) begin
         case (index)
            phti_pkg::REG_PROP_GAIN:     cfg_ff.prop_gain     <= csr_pwdata[14:0];
            phti_pkg::REG_INTEG_GAIN:    cfg_ff.integ_gain    <= csr_pwdata[7:0];
            phti_pkg::REG_INTEG_FLOOR:   cfg_ff.integ_floor   <= csr_pwdata;
            phti_pkg::REG_INTEG_CEILING: cfg_ff.integ_ceiling <= csr_pwdata;
            phti_pkg::REG_DRIVE_FLOOR:   cfg_ff.drive_floor   <= csr_pwdata[15:0];
            phti_pkg::REG_DRIVE_CEILING: cfg_ff.drive_ceiling <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         phti_pkg::REG_PROP_GAIN:     csr_prdata = {17'd0, cfg_ff.prop_gain};
         phti_pkg::REG_INTEG_GAIN:    csr_prdata = {24'd0, cfg_ff.integ_gain};
         phti_pkg::REG_INTEG_FLOOR:   csr_prdata = cfg_ff.integ_floor;
         phti_pkg::REG_INTEG_CEILING: csr_prdata = cfg_ff.integ_ceiling;
         phti_pkg::REG_DRIVE_FLOOR:
            csr_prdata = {{16{cfg_ff.drive_floor[15]}}, cfg_ff.drive_floor};
         phti_pkg::REG_DRIVE_CEILING:
            csr_prdata = {{16{cfg_ff.drive_ceiling[15]}}, cfg_ff.drive_ceiling};
         default: csr_prdata = '0;
      endcase
   end

endmodule

@@ hdl/phti_front.sv @@
`include "position_hold_pi_tiered_integral_assert.svh"

module phti_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic signed [15:0]     req_position_target,
   input  logic signed [15:0]     req_position_measured,
   input  logic signed [15:0]     req_speed_measured,
   input  logic                   q_pop,
   output logic                   q_valid,
   output phti_pkg::q_entry_type  q_head
);

   phti_pkg::q_entry_type              entry;
   phti_pkg::q_entry_type              mem_ff [phti_pkg::QDEPTH];
   logic [phti_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [phti_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [phti_pkg::QCNT_W-1:0]        count_ff, count_in;
   logic signed [16:0]                 err;
   logic signed [16:0]                 neg_err;
   logic [15:0]                        abs_err;
   logic signed [16:0]                 sh_err;
   logic [15:0]                        sh_abs;
   logic                               push;

   assign err     = {req_position_target[15], req_position_target}
                  - {req_position_measured[15], req_position_measured};
   assign neg_err = -err;
   assign abs_err = err[16] ? neg_err[15:0] : err[15:0];

   always_comb begin
      if (abs_err >= phti_pkg::TIER_COARSE) begin
         sh_err = err >>> 6;
         sh_abs = abs_err >> 7;
      end else if (abs_err >= phti_pkg::TIER_MID) begin
         sh_err = err >>> 4;
         sh_abs = abs_err >> 5;
      end else if (abs_err >= phti_pkg::TIER_FINE) begin
         sh_err = err >>> 3;
         sh_abs = abs_err >> 2;
      end else begin
         sh_err = err;
         sh_abs = abs_err >> 1;
      end
   end

   always_comb begin
      entry.err      = err;
      entry.se       = sh_err[11:0];
      entry.sa       = sh_abs[8:0];
      entry.spd_over = (req_speed_measured > phti_pkg::SPEED_MAX)
                    || (req_speed_measured < phti_pkg::SPEED_MIN);
   end

   assign req_ready = (count_ff != phti_pkg::QFULL);
   assign q_valid   = (count_ff != '0);
   assign q_head    = mem_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;

   always_comb begin
      wr_ptr_in = push  ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= entry;
      end
   end

   `PHTI_ASSERT_NOW(a_full_no_push, clock, reset, count_ff == phti_pkg::QFULL, !push)
   `PHTI_ASSERT_NOW(a_pop_nonempty, clock, reset, q_pop, count_ff != '0)

endmodule

@@ hdl/phti_back.sv @@
`include "position_hold_pi_tiered_integral_assert.svh"

module phti_back (
   input  logic                   clock,
   input  logic                   reset,
   input  phti_pkg::cfg_type      cfg,
   input  logic                   q_valid,
   input  phti_pkg::q_entry_type  q_head,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic signed [15:0]     rsp_drive_value,
   output logic signed [16:0]     rsp_position_error,
   output logic signed [31:0]     rsp_integ_value
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_GAIN,
      ST_MUL_SCALE,
      ST_ACC,
      ST_DRIVE
   } state_type;

   state_type             state_ff;
   phti_pkg::q_entry_type item_ff;
   logic signed [37:0]    prod_ff;
   logic signed [12:0]    p_ff;
   logic signed [31:0]    acc_ff;
   logic signed [31:0]    integ_ff;
   logic                  rsp_valid_ff;
   logic signed [15:0]    drive_ff;
   logic signed [16:0]    err_ff;
   logic signed [31:0]    integ_out_ff;

   logic signed [20:0]    mul_x;
   logic signed [16:0]    mul_y;
   logic signed [37:0]    mul_p;
   logic signed [37:0]    p_shift;
   logic signed [12:0]    p_in;
   logic signed [27:0]    inc;
   logic signed [32:0]    sum;
   logic signed [32:0]    sum_lo;
   logic signed [32:0]    sum_clip;
   logic signed [31:0]    acc_in;
   logic signed [16:0]    acc_hi;
   logic signed [17:0]    drv_sum;
   logic signed [15:0]    drv_clip;
   logic signed [15:0]    drive_in;
   logic signed [31:0]    integ_in;
   logic                  load_out;

   assign q_pop    = (state_ff == ST_IDLE) && q_valid;
   assign load_out = (state_ff == ST_DRIVE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      case (state_ff)
         ST_IDLE: begin
            mul_x = {6'd0, cfg.prop_gain};
            mul_y = q_head.err;
         end
         ST_MUL_GAIN: begin
            mul_x = {{9{item_ff.se[11]}}, item_ff.se};
            mul_y = {9'd0, cfg.integ_gain};
         end
         ST_MUL_SCALE: begin
            mul_x = prod_ff[20:0];
            mul_y = {8'd0, item_ff.sa};
         end
         default: begin
            mul_x = '0;
            mul_y = '0;
         end
      endcase
   end

   assign mul_p = mul_x * mul_y;

   always_comb begin
      p_shift = prod_ff >>> 3;
      if (p_shift > phti_pkg::P_MAX) begin
         p_in = phti_pkg::P_MAX;
      end else if (p_shift < phti_pkg::P_MIN) begin
         p_in = phti_pkg::P_MIN;
      end else begin
         p_in = p_shift[12:0];
      end
   end

   always_comb begin
      inc      = prod_ff[27:0];
      sum      = {integ_ff[31], integ_ff} + {{5{inc[27]}}, inc};
      sum_lo   = (sum < cfg.integ_floor) ? 33'(cfg.integ_floor) : sum;
      sum_clip = (sum_lo > cfg.integ_ceiling) ? 33'(cfg.integ_ceiling) : sum_lo;
      acc_in   = item_ff.spd_over ? '0 : sum_clip[31:0];
   end

   always_comb begin
      acc_hi  = acc_ff[31:15];
      drv_sum = {{5{p_ff[12]}}, p_ff} + {acc_hi[16], acc_hi};
      if (drv_sum > cfg.drive_ceiling) begin
         drv_clip = cfg.drive_ceiling;
      end else if (drv_sum < cfg.drive_floor) begin
         drv_clip = cfg.drive_floor;
      end else begin
         drv_clip = drv_sum[15:0];
      end
      drive_in = drv_clip;
      integ_in = acc_ff;
      if (item_ff.err > 17'sd0 && drv_clip > phti_pkg::DRIVE_PIN_MAX) begin
         drive_in = phti_pkg::DRIVE_PIN_MAX;
         integ_in = phti_pkg::PIN_ACCUM_MAX;
      end else if (item_ff.err < 17'sd0 && drv_clip < phti_pkg::DRIVE_PIN_MIN) begin
         drive_in = phti_pkg::DRIVE_PIN_MIN;
         integ_in = phti_pkg::PIN_ACCUM_MIN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         integ_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  item_ff  <= q_head;
                  prod_ff  <= mul_p;
                  state_ff <= ST_MUL_GAIN;
               end
            end
            ST_MUL_GAIN: begin
               p_ff     <= p_in;
               prod_ff  <= mul_p;
               state_ff <= ST_MUL_SCALE;
            end
            ST_MUL_SCALE: begin
               prod_ff  <= mul_p;
               state_ff <= ST_ACC;
            end
            ST_ACC: begin
               acc_ff   <= acc_in;
               state_ff <= ST_DRIVE;
            end
            ST_DRIVE: begin
               if (load_out) begin
                  integ_ff     <= integ_in;
                  drive_ff     <= drive_in;
                  err_ff       <= item_ff.err;
                  integ_out_ff <= integ_in;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_drive_value    = drive_ff;
   assign rsp_position_error = err_ff;
   assign rsp_integ_value    = integ_out_ff;

   `PHTI_ASSERT_NEXT(a_load_shows, clock, reset, load_out, rsp_valid_ff)
   `PHTI_ASSERT_NOW(a_no_overwrite, clock, reset, rsp_valid_ff && !rsp_ready, !load_out)

endmodule

@@ sim/position_loop_checker.sv @@
`timescale 1ns / 100ps

module position_loop_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic signed [15:0]            req_position_target,
   input  logic signed [15:0]            req_position_measured,
   input  logic signed [15:0]            req_speed_measured,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic signed [15:0]            rsp_drive_value,
   input  logic signed [16:0]            rsp_position_error,
   input  logic signed [31:0]            rsp_integ_value,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [phti_pkg::PADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   input  logic                          csr_pready,
   output int                            mismatch_count,
   output int                            pending_count
);

   localparam longint DRIVE_PIN   = 3000;
   localparam longint P_LIMIT     = 3000;
   localparam longint SPEED_LIMIT = 50;
   localparam longint ACCUM_PIN   = 3000 * 32768;

   typedef struct {
      logic signed [15:0] drive;
      logic signed [16:0] error;
      logic signed [31:0] integ;
   } drive_result_type;

   drive_result_type expected_drives[$];

   logic [14:0]        kp;
   logic [7:0]         ki;
   logic signed [31:0] integ_lo;
   logic signed [31:0] integ_hi;
   logic signed [15:0] drive_lo;
   logic signed [15:0] drive_hi;
   longint             accum;
   int                 failures;

   function automatic drive_result_type step_position_loop(input logic signed [15:0] tgt,
                                                           input logic signed [15:0] meas,
                                                           input logic signed [15:0] spd);
      drive_result_type res;
      longint err, p, mag, inc, acc, drv;
      err = longint'(tgt) - longint'(meas);
      p = (longint'(kp) * err) >>> 3;
      if (p > P_LIMIT) begin
         p = P_LIMIT;
      end else if (p < -P_LIMIT) begin
         p = -P_LIMIT;
      end
      mag = (err < 0) ? -err : err;
      if (mag >= 250) begin
         inc = longint'(ki) * (err >>> 6) * (mag >>> 7);
      end else if (mag >= 100) begin
         inc = longint'(ki) * (err >>> 4) * (mag >>> 5);
      end else if (mag >= 30) begin
         inc = longint'(ki) * (err >>> 3) * (mag >>> 2);
      end else begin
         inc = longint'(ki) * err * (mag >>> 1);
      end
      acc = accum + inc;
      if (acc < longint'(integ_lo)) acc = longint'(integ_lo);
      if (acc > longint'(integ_hi)) acc = longint'(integ_hi);
      if (longint'(spd) > SPEED_LIMIT || longint'(spd) < -SPEED_LIMIT) acc = 0;
      drv = p + (acc >>> 15);
      if (drv > longint'(drive_hi)) begin
         drv = longint'(drive_hi);
      end else if (drv < longint'(drive_lo)) begin
         drv = longint'(drive_lo);
      end
      if (err > 0 && drv > DRIVE_PIN) begin
         drv = DRIVE_PIN;
         acc = ACCUM_PIN;
      end else if (err < 0 && drv < -DRIVE_PIN) begin
         drv = -DRIVE_PIN;
         acc = -ACCUM_PIN;
      end
      accum = acc;
      res.drive = drv[15:0];
      res.error = err[16:0];
      res.integ = acc[31:0];
      return res;
   endfunction

   always @(posedge clock) begin
      drive_result_type want;
      if (reset) begin
         kp = '0;
         ki = '0;
         integ_lo = phti_pkg::INTEG_FLOOR_RST;
         integ_hi = phti_pkg::INTEG_CEILING_RST;
         drive_lo = phti_pkg::DRIVE_FLOOR_RST;
         drive_hi = phti_pkg::DRIVE_CEILING_RST;
         accum = 0;
         failures = 0;
         expected_drives.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[phti_pkg::PADDR_W-1:2])
               phti_pkg::REG_PROP_GAIN:     kp = csr_pwdata[14:0];
               phti_pkg::REG_INTEG_GAIN:    ki = csr_pwdata[7:0];
               phti_pkg::REG_INTEG_FLOOR:   integ_lo = csr_pwdata;
               phti_pkg::REG_INTEG_CEILING: integ_hi = csr_pwdata;
               phti_pkg::REG_DRIVE_FLOOR:   drive_lo = csr_pwdata[15:0];
               phti_pkg::REG_DRIVE_CEILING: drive_hi = csr_pwdata[15:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_drives.size() == 0) begin
               failures++;
               if (failures <= 10) begin
                  $display("unexpected response: drive %0d error %0d integ %0d",
                           rsp_drive_value, rsp_position_error, rsp_integ_value);
               end
            end else begin
               want = expected_drives.pop_front();
               if (rsp_drive_value !== want.drive || rsp_position_error !== want.error ||
                   rsp_integ_value !== want.integ) begin
                  failures++;
                  if (failures <= 10) begin
                     $display("response differs at %0t: expected drive %0d error %0d integ %0d",
                              $realtime, want.drive, want.error, want.integ);
                     $display("   got drive %0d error %0d integ %0d",
                              rsp_drive_value, rsp_position_error, rsp_integ_value);
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            expected_drives.push_back(step_position_loop(req_position_target,
                                                         req_position_measured,
                                                         req_speed_measured));
         end
      end
      mismatch_count <= failures;
      pending_count  <= expected_drives.size();
   end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

   localparam int IDLE_LIMIT = 4000;
   localparam int LONG_HOLD  = 400;
   localparam int PHASES     = 10;
   localparam int PHASE_LEN  = 128;

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_ready;
   logic signed [15:0]              req_position_target;
   logic signed [15:0]              req_position_measured;
   logic signed [15:0]              req_speed_measured;
   logic                            rsp_valid;
   logic                            rsp_ready;
   logic signed [15:0]              rsp_drive_value;
   logic signed [16:0]              rsp_position_error;
   logic signed [31:0]              rsp_integ_value;
   logic                            csr_psel;
   logic                            csr_penable;
   logic                            csr_pwrite;
   logic [phti_pkg::PADDR_W-1:0]    csr_paddr;
   logic [31:0]                     csr_pwdata;
   logic [31:0]                     csr_prdata;
   logic                            csr_pready;

   int mismatches;
   int pending;
   bit steady;
   int hold_requests = 0;

   position_hold_pi_tiered_integral i_dut (.*);

   position_loop_checker i_checker (
      .clock, .reset,
      .req_valid, .req_ready, .req_position_target, .req_position_measured,
      .req_speed_measured,
      .rsp_valid, .rsp_ready, .rsp_drive_value, .rsp_position_error, .rsp_integ_value,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata, .csr_pready,
      .mismatch_count(mismatches), .pending_count(pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   task automatic send_request(input logic signed [15:0] tgt,
                               input logic signed [15:0] meas,
                               input logic signed [15:0] spd);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid             <= 1'b1;
      req_position_target   <= tgt;
      req_position_measured <= meas;
      req_speed_measured    <= spd;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_random_request();
      int r, mag, err, meas, tgt, spd;
      r = $urandom_range(0, 99);
      if (r < 12) begin
         tgt  = $urandom_range(0, 65535);
         meas = $urandom_range(0, 65535);
         spd  = $urandom_range(0, 65535);
      end else begin
         case ($urandom_range(0, 3))
            0:       mag = $urandom_range(0, 29);
            1:       mag = $urandom_range(30, 99);
            2:       mag = $urandom_range(100, 249);
            default: mag = $urandom_range(250, 2000);
         endcase
         err  = $urandom_range(0, 1) ? mag : -mag;
         meas = int'($urandom_range(0, 65535)) - 32768;
         tgt  = meas + err;
         if (tgt > 32767 || tgt < -32768) tgt = meas - err;
         r = $urandom_range(0, 99);
         if (r < 80) begin
            spd = int'($urandom_range(0, 100)) - 50;
         end else if (r < 90) begin
            spd = $urandom_range(0, 1) ? int'($urandom_range(51, 300))
                                       : -int'($urandom_range(51, 300));
         end else begin
            spd = $urandom_range(0, 65535);
         end
      end
      send_request(tgt[15:0], meas[15:0], spd[15:0]);
   endtask

   task automatic csr_write(input logic [2:0] index, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_until_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic load_settings(input logic [31:0] kp, input logic [31:0] ki,
                                input logic [31:0] ilo, input logic [31:0] ihi,
                                input logic [31:0] dlo, input logic [31:0] dhi);
      csr_write(phti_pkg::REG_PROP_GAIN, kp);
      csr_write(phti_pkg::REG_INTEG_GAIN, ki);
      csr_write(phti_pkg::REG_INTEG_FLOOR, ilo);
      csr_write(phti_pkg::REG_INTEG_CEILING, ihi);
      csr_write(phti_pkg::REG_DRIVE_FLOOR, dlo);
      csr_write(phti_pkg::REG_DRIVE_CEILING, dhi);
   endtask

   // receiver side
   initial begin
      int gap;
      int holds_done;
      holds_done = 0;
      rsp_ready = 1'b0;
      forever begin
         if (holds_done != hold_requests) begin
            holds_done = hold_requests;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            gap = pick_gap();
            if (gap > 0) begin
               rsp_ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   end

   initial begin
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_psel && csr_penable && csr_pwrite && csr_pready)) begin
            idle = 0;
         end else begin
            idle++;
         end
      end
      $display("position_hold_pi_tiered_integral: mismatch");
      $finish;
   end

   initial begin
      reset                 = 1'b1;
      req_valid             = 1'b0;
      req_position_target   = '0;
      req_position_measured = '0;
      req_speed_measured    = '0;
      csr_psel              = 1'b0;
      csr_penable           = 1'b0;
      csr_pwrite            = 1'b0;
      csr_paddr             = '0;
      csr_pwdata            = '0;
      steady                = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: gains at zero
      send_request(16'sd100, 16'sd0, 16'sd0);
      send_request(-16'sd300, 16'sd0, 16'sd0);
      wait_until_idle();

      load_settings(32'd32767, 32'd255, 32'h8000_0000, 32'h7fff_ffff,
                    32'hffff_8000, 32'h0000_7fff);
      send_request(16'sh7fff, 16'sh8000, 16'sd0);
      send_request(16'sh8000, 16'sh7fff, 16'sd0);
      send_request(16'sd0, 16'sd0, 16'sd0);
      send_request(16'sd250, 16'sd0, 16'sd0);
      send_request(16'sd249, 16'sd0, 16'sd0);
      send_request(16'sd100, 16'sd0, 16'sd0);
      send_request(16'sd99, 16'sd0, 16'sd0);
      send_request(16'sd30, 16'sd0, 16'sd0);
      send_request(16'sd29, 16'sd0, 16'sd0);
      send_request(16'sd1, 16'sd0, 16'sd0);
      send_request(16'sd0, 16'sd250, 16'sd0);
      send_request(16'sd0, 16'sd249, 16'sd0);
      send_request(16'sd0, 16'sd100, 16'sd0);
      send_request(16'sd0, 16'sd99, 16'sd0);
      send_request(16'sd0, 16'sd30, 16'sd0);
      send_request(16'sd0, 16'sd29, 16'sd0);
      send_request(16'sd0, 16'sd1, 16'sd0);
      send_request(16'sd10, 16'sd0, 16'sd50);
      send_request(16'sd10, 16'sd0, 16'sd51);
      send_request(16'sd10, 16'sd0, -16'sd50);
      send_request(16'sd10, 16'sd0, -16'sd51);
      send_request(16'sd10, 16'sd0, 16'sh7fff);
      send_request(16'sd10, 16'sd0, 16'sh8000);
      wait_until_idle();

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: load_settings(32'd32767, 32'd255, 32'h8000_0000, 32'h7fff_ffff,
                             32'hffff_8000, 32'h0000_7fff);
            1: load_settings(32'd0, 32'd0, phti_pkg::INTEG_FLOOR_RST,
                             phti_pkg::INTEG_CEILING_RST,
                             32'(phti_pkg::DRIVE_FLOOR_RST),
                             32'(phti_pkg::DRIVE_CEILING_RST));
            2: load_settings($urandom_range(0, 32767), $urandom_range(0, 255),
                             32'd5000000, -32'sd5000000, -32'sd3000, 32'sd3000);
            3: load_settings($urandom_range(0, 32767), $urandom_range(0, 255),
                             phti_pkg::INTEG_FLOOR_RST, phti_pkg::INTEG_CEILING_RST,
                             32'sd1000, -32'sd1000);
            4: load_settings($urandom_range(0, 64), 32'd255, -32'sd100000, 32'sd100000,
                             -32'sd3000, 32'sd3000);
            default: load_settings($urandom_range(0, 32767), $urandom_range(0, 255),
                                   -int'($urandom_range(0, 32'h7fff_ffff)),
                                   $urandom_range(0, 32'h7fff_ffff),
                                   $urandom_range(0, 65535), $urandom_range(0, 65535));
         endcase
         steady = (ph % 4 == 2);
         if (ph == 3) hold_requests++;
         repeat (PHASE_LEN) send_random_request();
         wait_until_idle();
      end

      repeat (20) @(posedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("position_hold_pi_tiered_integral: match");
      end else begin
         $display("position_hold_pi_tiered_integral: mismatch");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+hdl
hdl/phti_pkg.sv
hdl/phti_csr.sv
hdl/phti_front.sv
hdl/phti_back.sv
hdl/position_hold_pi_tiered_integral.sv
sim/position_loop_checker.sv
sim/testbench.sv
